/* rtl/nnr_pkg.sv */
`timescale 1ns / 1ps
package nnr_pkg;
    localparam int MAX_DEGREE_DEF = 15;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORD_W         = 32;
    localparam int DEG_W          = 4;
    localparam int CAUSE_W        = 3;
    localparam int EPS_W          = 16;
    localparam int ITER_W         = 8;

    localparam logic [CAUSE_W-1:0] CAUSE_RESIDUAL = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_STEP     = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_SLOPE    = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_LIMIT    = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_TRIVIAL  = 3'd4;

    localparam logic EPS_RESET_BIT = 1'b1;
    localparam logic [ITER_W-1:0] ITER_RESET = 8'd100;

    localparam logic REG_EPSILON  = 1'b0;
    localparam logic REG_MAX_ITER = 1'b1;
endpackage

/* rtl/nnr_divider.sv */
`timescale 1ns / 1ps
module nnr_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import nnr_pkg::*;

    // restoring divider, one quotient bit per cycle, saturated to 32 bits
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [64:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[63]};
        trial     = shifted - {33'd0, dvs_reg};
        if (go)
        begin
            rem_next = 64'd0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = 7'd0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = (quo_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo_reg[31:0];
endmodule

/* rtl/newton_nth_root_top.sv */
`timescale 1ns / 1ps
// channel   | ports                              | handshake
// request   | radicand, root_degree              | start && !busy
// result    | root, stop_cause                   | done strobe, one cycle
// config    | psel penable pwrite paddr pwdata   | apb write, pready high
// one request: degree 0 or 1 goes straight from accept to the output state;
// otherwise each Newton step runs x^n and x^(n-1) through the shared
// multiplier (states POW, MUL, ACC per multiply) and then the bit-serial
// divide, until a stop cause or the iteration limit is reached.
// rst_n clears control and loads epsilon 1 and an iteration limit of 100.
// the receiver cannot stall; done pulses once per request.
module newton_nth_root_top
#(
    parameter int MAX_DEGREE = nnr_pkg::MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = nnr_pkg::FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [nnr_pkg::WORD_W-1:0]  radicand,
    input  logic [nnr_pkg::DEG_W-1:0]   root_degree,
    output logic                        done,
    output logic [nnr_pkg::WORD_W-1:0]  root,
    output logic [nnr_pkg::CAUSE_W-1:0] stop_cause,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import nnr_pkg::*;

    localparam logic [DEG_W-1:0] DEG_CAP =
        (MAX_DEGREE > 15) ? 4'd15 : DEG_W'(MAX_DEGREE);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POW   = 4'd1;
    localparam logic [3:0] S_RES   = 4'd2;
    localparam logic [3:0] S_SLOPE = 4'd3;
    localparam logic [3:0] S_SCHK  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_ACC   = 4'd9;
    localparam logic [3:0] S_SMUL  = 4'd10;

    // configuration registers
    logic [EPS_W-1:0]  eps_reg;
    logic [ITER_W-1:0] iter_max_reg;
    logic              wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg      <= {{(EPS_W-1){1'b0}}, EPS_RESET_BIT};
            iter_max_reg <= ITER_RESET;
        end
        else if (wr_en && paddr[2] == REG_EPSILON && paddr[1:0] == 2'd0)
            eps_reg <= pwdata[EPS_W-1:0];
        else if (wr_en && paddr[2] == REG_MAX_ITER && paddr[1:0] == 2'd0)
            iter_max_reg <= pwdata[ITER_W-1:0];
    end

    always_comb
    begin
        prdata = 32'd0;
        case (paddr[2])
            REG_EPSILON:  prdata = {16'd0, eps_reg};
            REG_MAX_ITER: prdata = {24'd0, iter_max_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // datapath registers
    logic [3:0]        st_reg, st_next, ret_reg, ret_next;
    logic [31:0]       a_reg, a_next, x_reg, x_next, acc_reg, acc_next;
    logic [31:0]       mag_reg, mag_next, slope_reg, slope_next;
    logic              pos_reg, pos_next;
    logic [DEG_W-1:0]  n_reg, n_next, k_reg, k_next;
    logic [ITER_W-1:0] it_reg, it_next;
    logic [31:0]       out_root_reg, out_root_next;
    logic [2:0]        out_cause_reg, out_cause_next;
    logic              done_reg, done_next;
    logic [31:0]       mop_reg, mop_next;
    logic [63:0]       prod_reg;
    logic [63:0]       psh;
    logic [31:0]       pmul_sat;
    logic [31:0]       one_fx;
    logic [DEG_W-1:0]  n_in;
    logic              accept;
    logic              div_go, div_done;
    logic [31:0]       div_q;
    logic [32:0]       xsum;
    logic [31:0]       xnew, diff;

    // one fixed-point 1.0, saturated
    assign one_fx = (FRAC_BITS >= 32) ? 32'hFFFF_FFFF : 32'(64'd1 << FRAC_BITS);

    // shared multiplier, registered
    always_ff @(posedge clk)
        prod_reg <= {32'd0, acc_reg} * {32'd0, mop_reg};
    assign psh      = prod_reg >> FRAC_BITS;
    assign pmul_sat = (psh[63:32] != 32'd0) ? 32'hFFFF_FFFF : psh[31:0];

    nnr_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend ({32'd0, mag_reg} << FRAC_BITS),
        .divisor  (slope_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign accept = start && !busy;
    assign n_in = (root_degree > DEG_CAP) ? DEG_CAP : root_degree;
    assign xsum = {1'b0, x_reg} + {1'b0, div_q};
    always_comb
    begin
        if (pos_reg)
            xnew = (div_q > x_reg) ? 32'd0 : x_reg - div_q;
        else
            xnew = xsum[32] ? 32'hFFFF_FFFF : xsum[31:0];
        diff = (xnew > x_reg) ? xnew - x_reg : x_reg - xnew;
    end

    // sequencer
    always_comb
    begin
        st_next        = st_reg;
        ret_next       = ret_reg;
        a_next         = a_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        mop_next       = mop_reg;
        mag_next       = mag_reg;
        slope_next     = slope_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        it_next        = it_reg;
        out_root_next  = out_root_reg;
        out_cause_next = out_cause_reg;
        done_next      = 1'b0;
        div_go         = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    a_next  = radicand;
                    n_next  = n_in;
                    x_next  = radicand >> 1;
                    it_next = '0;
                    if (n_in <= 4'd1)
                    begin
                        out_root_next  = (n_in == 4'd0) ? 32'd0 : radicand;
                        out_cause_next = CAUSE_TRIVIAL;
                        st_next        = S_OUT;
                    end
                    else
                    begin
                        acc_next = one_fx;
                        k_next   = n_in;
                        st_next  = S_POW;
                    end
                end
            end
            S_POW:
            begin
                // x^n - a first; x^(n-1) is handled after the residual check
                if (it_reg == iter_max_reg)
                begin
                    out_root_next  = x_reg;
                    out_cause_next = CAUSE_LIMIT;
                    st_next        = S_OUT;
                end
                else if (k_reg == 4'd0)
                    st_next = ret_reg;
                else
                begin
                    mop_next = x_reg;
                    st_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                // product register loads at the end of this cycle
                st_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = pmul_sat;
                k_next   = k_reg - 4'd1;
                st_next  = S_POW;
            end
            S_RES:
            begin
                pos_next = acc_reg > a_reg;
                mag_next = (acc_reg > a_reg) ? acc_reg - a_reg : a_reg - acc_reg;
                if (((acc_reg > a_reg) ? acc_reg - a_reg : a_reg - acc_reg)
                    < {16'd0, eps_reg})
                begin
                    out_root_next  = x_reg;
                    out_cause_next = CAUSE_RESIDUAL;
                    st_next        = S_OUT;
                end
                else
                begin
                    acc_next = one_fx;
                    k_next   = n_reg - 4'd1;
                    ret_next = S_SLOPE;
                    st_next  = S_POW;
                end
            end
            S_SLOPE:
            begin
                // n * x^(n-1), saturated
                mop_next = {28'd0, n_reg};
                st_next  = S_SMUL;
            end
            S_SMUL:
            begin
                st_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (prod_reg[63:32] != 32'd0)
                    slope_next = 32'hFFFF_FFFF;
                else
                    slope_next = prod_reg[31:0];
                if ((prod_reg[63:32] == 32'd0) &&
                    (prod_reg[31:0] == 32'd0 || prod_reg[31:0] < {16'd0, eps_reg}))
                begin
                    out_root_next  = x_reg;
                    out_cause_next = CAUSE_SLOPE;
                    st_next        = S_OUT;
                end
                else
                begin
                    div_go  = 1'b0;
                    st_next = S_DIV;
                    ret_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (ret_reg == S_IDLE)
                begin
                    div_go   = 1'b1;
                    ret_next = S_DIV;
                end
                else if (div_done)
                    st_next = S_UPD;
            end
            S_UPD:
            begin
                if (diff < {16'd0, eps_reg})
                begin
                    out_root_next  = x_reg;
                    out_cause_next = CAUSE_STEP;
                    st_next        = S_OUT;
                end
                else
                begin
                    x_next   = xnew;
                    it_next  = it_reg + 8'd1;
                    acc_next = one_fx;
                    k_next   = n_reg;
                    ret_next = S_RES;
                    st_next  = S_POW;
                end
            end
            S_OUT:
            begin
                done_next = 1'b1;
                st_next   = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
        if (st_reg == S_IDLE && accept && n_in > 4'd1)
            ret_next = S_RES;
    end

    // slope multiply needs product of n and acc (unshifted): acc*n in prod_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg       <= ret_next;
        a_reg         <= a_next;
        x_reg         <= x_next;
        acc_reg       <= acc_next;
        mop_reg       <= mop_next;
        mag_reg       <= mag_next;
        slope_reg     <= slope_next;
        pos_reg       <= pos_next;
        n_reg         <= n_next;
        k_reg         <= k_next;
        it_reg        <= it_next;
        out_root_reg  <= out_root_next;
        out_cause_reg <= out_cause_next;
    end

    assign busy       = (st_reg != S_IDLE) || done_reg;
    assign done       = done_reg;
    assign root       = out_root_reg;
    assign stop_cause = out_cause_reg;
endmodule

/* test/nnr_checker.sv */
`timescale 1ns / 1ps
module nnr_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [nnr_pkg::WORD_W-1:0]   radicand,
    input  logic [nnr_pkg::DEG_W-1:0]    root_degree,
    input  logic                         done,
    input  logic [nnr_pkg::WORD_W-1:0]   root,
    input  logic [nnr_pkg::CAUSE_W-1:0]  stop_cause,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output int                           fail_count,
    output int                           pending
);
    import nnr_pkg::*;

    localparam logic [63:0] WORD_SAT = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [WORD_W-1:0]  root;
        logic [CAUSE_W-1:0] cause;
    } root_result_t;

    root_result_t        expected_roots[$];
    logic [EPS_W-1:0]    tol;
    logic [ITER_W-1:0]   step_limit;

    function automatic logic [63:0] clip_word(logic [63:0] v);
        return (v > WORD_SAT) ? WORD_SAT : v;
    endfunction

    function automatic logic [63:0] fixed_mul(logic [63:0] a, logic [63:0] b);
        return clip_word((a * b) >> FRAC_BITS_DEF);
    endfunction

    function automatic logic [63:0] fixed_power(logic [63:0] x, int k);
        logic [63:0] acc;
        acc = clip_word(64'd1 << FRAC_BITS_DEF);
        for (int i = 0; i < k; i++)
            acc = fixed_mul(acc, x);
        return acc;
    endfunction

    // newton search for the n-th root, same stopping order as the block
    function automatic root_result_t solve_root(logic [WORD_W-1:0] a_in,
                                                logic [DEG_W-1:0] deg_in);
        root_result_t r;
        logic [63:0] a, x, xn, mag, slope, step, xnew, diff;
        logic [CAUSE_W-1:0] cause;
        logic above;
        int n;
        a = {32'd0, a_in};
        n = (deg_in > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : deg_in;
        if (n <= 1)
        begin
            r.root = (n == 0) ? '0 : a_in;
            r.cause = CAUSE_TRIVIAL;
            return r;
        end
        x = a >> 1;
        cause = CAUSE_LIMIT;
        for (int it = 0; it < step_limit; it++)
        begin
            xn = fixed_power(x, n);
            above = xn > a;
            mag = above ? xn - a : a - xn;
            if (mag < tol)
            begin
                cause = CAUSE_RESIDUAL;
                break;
            end
            slope = clip_word(64'(n) * fixed_power(x, n - 1));
            if (slope == 0 || slope < tol)
            begin
                cause = CAUSE_SLOPE;
                break;
            end
            step = clip_word((mag << FRAC_BITS_DEF) / slope);
            if (above)
                xnew = (step > x) ? 64'd0 : x - step;
            else
                xnew = clip_word(x + step);
            diff = (xnew > x) ? xnew - x : x - xnew;
            if (diff < tol)
            begin
                cause = CAUSE_STEP;
                break;
            end
            x = xnew;
        end
        r.root = x[WORD_W-1:0];
        r.cause = cause;
        return r;
    endfunction

    assign pending = expected_roots.size();

    // register shadow, request capture and result compare
    always @(posedge clk or negedge rst_n)
    begin
        root_result_t want;
        if (!rst_n)
        begin
            tol <= EPS_W'(EPS_RESET_BIT);
            step_limit <= ITER_RESET;
            fail_count <= 0;
            expected_roots.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_EPSILON)
                    tol <= pwdata[EPS_W-1:0];
                else
                    step_limit <= pwdata[ITER_W-1:0];
            end
            if (start && !busy)
                expected_roots.push_back(solve_root(radicand, root_degree));
            if (done)
            begin
                if (expected_roots.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result root=%h cause=%0d", root, stop_cause);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (want.root !== root || want.cause !== stop_cause)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected root=%h cause=%0d, got root=%h cause=%0d",
                                     want.root, want.cause, root, stop_cause);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;
    import nnr_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [WORD_W-1:0]   radicand = '0;
    logic [DEG_W-1:0]    root_degree = '0;
    logic                done;
    logic [WORD_W-1:0]   root;
    logic [CAUSE_W-1:0]  stop_cause;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;
    int                  idle_pct = 0;

    always #1 clk = ~clk;

    newton_nth_root_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .radicand(radicand), .root_degree(root_degree), .done(done),
        .root(root), .stop_cause(stop_cause), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    nnr_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .radicand(radicand), .root_degree(root_degree), .done(done),
        .root(root), .stop_cause(stop_cause), .psel(psel), .penable(penable),
        .pwrite(pwrite), .pready(pready), .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending)
    );

    // drive one request and return at the edge that accepts it
    task automatic send_request(logic [WORD_W-1:0] a, logic [DEG_W-1:0] n);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        radicand <= a;
        root_degree <= n;
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        @(posedge clk);
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic reg_sel, logic [31:0] value);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // random radicand: products of n small factors, small values, or full width
    function automatic logic [WORD_W-1:0] pick_radicand(logic [DEG_W-1:0] n);
        logic [63:0] p;
        case ($urandom_range(3))
            0:
            begin
                p = 64'd1 << 16;
                for (int i = 0; i < n; i++)
                    p = (p * $urandom_range(1, 3)) & 64'hFFFF_FFFF_FFFF;
                return (p > 64'hFFFF_FFFF) ? $urandom : p[31:0];
            end
            1: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(int count, logic [15:0] eps, logic [7:0] iters);
        logic [DEG_W-1:0] n;
        write_reg(REG_EPSILON, {16'd0, eps});
        write_reg(REG_MAX_ITER, {24'd0, iters});
        for (int i = 0; i < count; i++)
        begin
            n = ($urandom_range(9) == 0) ? DEG_W'($urandom_range(0, 1))
                                         : DEG_W'($urandom_range(2, 15));
            send_request(pick_radicand(n), n);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, field extremes, trivial degrees
        send_request(32'h0000_0000, 4'd0);
        send_request(32'hFFFF_FFFF, 4'd0);
        send_request(32'hFFFF_FFFF, 4'd1);
        send_request(32'h0001_2345, 4'd1);
        send_request(32'h0004_0000, 4'd2);
        send_request(32'h0008_0000, 4'd3);
        send_request(32'h0001_0000, 4'd2);
        send_request(32'hFFFF_FFFF, 4'd2);
        send_request(32'h0000_0001, 4'd15);
        send_request(32'h0002_0000, 4'd15);

        // zero tolerance: a zero slope still stops the search
        write_reg(REG_EPSILON, 32'd0);
        send_request(32'h0000_0000, 4'd2);
        send_request(32'h0000_0001, 4'd5);
        send_request(32'h0009_0000, 4'd2);

        // zero and tiny iteration limits
        write_reg(REG_MAX_ITER, 32'd0);
        send_request(32'h1234_5678, 4'd3);
        send_request(32'hFFFF_FFFF, 4'd15);
        write_reg(REG_MAX_ITER, 32'd1);
        send_request(32'h0010_0000, 4'd4);

        // widest tolerance stops quickly
        write_reg(REG_EPSILON, 32'h0000_FFFF);
        write_reg(REG_MAX_ITER, 32'd255);
        send_request(32'h0004_0000, 4'd2);
        send_request(32'hFFFF_FFFF, 4'd15);
        send_request(32'h0000_8000, 4'd7);

        // largest limit with tight tolerance, few requests since each is slow
        write_reg(REG_EPSILON, 32'd1);
        send_request(32'hFFFF_FFFF, 4'd15);
        send_request(32'h8000_0000, 4'd2);

        // random phases with the three idling patterns
        idle_pct = 15;
        run_random(250, 16'd1, 8'd4);
        run_random(250, 16'd0, 8'd8);
        idle_pct = 54;
        run_random(250, 16'hFFFF, 8'd6);
        run_random(250, 16'd16, 8'd2);
        idle_pct = 0;
        run_random(250, 16'd256, 8'd8);
        run_random(240, 16'd3, 8'd1);
        run_random(10, 16'd1, 8'd100);

        wait_idle();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule
